// ===== rtl/grd_pkg.sv =====
`timescale 1ns / 1ps

package grd_pkg;

   // Field widths
   localparam int RAW_W      = 16;
   localparam int TS_W       = 32;
   localparam int RATE_W     = 11;
   localparam int DIFF_W     = 12;
   localparam int THR_W      = 11;
   localparam int SETTLE_W   = 8;
   localparam int ANGLE_W    = 48;
   localparam int PROD_W     = 45;
   localparam int STATE_W    = 2;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 11;

   // Converter word layout
   localparam int DONE_BIT_POS = 13;
   localparam int RATE_LSB     = 1;

   // Detector states
   localparam logic [STATE_W-1:0] ST_IDLE     = 2'd0;
   localparam logic [STATE_W-1:0] ST_ROTATING = 2'd1;
   localparam logic [STATE_W-1:0] ST_SETTLING = 2'd2;
   localparam logic [STATE_W-1:0] ST_DONE     = 2'd3;

   // Register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_ZERO_OFFSET = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_THRESHOLD   = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_SETTLE      = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_DEAD_BAND   = 2'd3;

   // Register reset values
   localparam logic [RATE_W-1:0]   ZERO_OFFSET_RST = 11'd1008;
   localparam logic [THR_W-1:0]    THRESHOLD_RST   = 11'd50;
   localparam logic [SETTLE_W-1:0] SETTLE_RST      = 8'd10;
   localparam logic [THR_W-1:0]    DEAD_BAND_RST   = 11'd10;

   localparam logic [SETTLE_W-1:0] QUIET_MAX = 8'd255;

   // Saturation limits of the angle accumulator
   localparam logic signed [ANGLE_W-1:0] ANGLE_MAX = {1'b0, {(ANGLE_W-1){1'b1}}};
   localparam logic signed [ANGLE_W-1:0] ANGLE_MIN = {1'b1, {(ANGLE_W-1){1'b0}}};

   typedef struct packed {
      logic [RATE_W-1:0]   zero_offset;
      logic [THR_W-1:0]    threshold;
      logic [SETTLE_W-1:0] settle;
      logic [THR_W-1:0]    dead_band;
   } cfg_type;

   // Classified item between front and back
   typedef struct packed {
      logic                     cmd;
      logic                     ok;
      logic signed [DIFF_W-1:0] diff;
      logic [RATE_W-1:0]        mag;
      logic [TS_W-1:0]          ts;
   } item_type;

endpackage

// ===== rtl/grd_front.sv =====
`timescale 1ns / 1ps

module grd_front (
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [grd_pkg::RAW_W-1:0]  raw_word,
   input  logic [grd_pkg::TS_W-1:0]   timestamp_ms,
   input  logic                       cmd,
   input  grd_pkg::cfg_type           cfg,
   input  logic                       q_ready,
   output logic                       q_push,
   output grd_pkg::item_type          q_item
);

   logic [grd_pkg::RATE_W-1:0]        rate;
   logic signed [grd_pkg::DIFF_W-1:0] diff;
   logic signed [grd_pkg::DIFF_W-1:0] diff_neg;

   // Accept whenever the queue has room
   assign req_tready = q_ready;
   assign q_push     = req_tvalid & q_ready;

   // Extract rate and take its offset from zero
   assign rate     = raw_word[grd_pkg::RATE_LSB +: grd_pkg::RATE_W];
   assign diff     = $signed({1'b0, rate}) - $signed({1'b0, cfg.zero_offset});
   assign diff_neg = -diff;

   always_comb begin
      q_item.cmd  = cmd;
      q_item.ok   = raw_word[grd_pkg::DONE_BIT_POS];
      q_item.diff = diff;
      q_item.mag  = diff[grd_pkg::DIFF_W-1] ? diff_neg[grd_pkg::RATE_W-1:0]
                                            : diff[grd_pkg::RATE_W-1:0];
      q_item.ts   = timestamp_ms;
   end

endmodule

// ===== rtl/grd_queue.sv =====
`timescale 1ns / 1ps

module grd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  grd_pkg::item_type push_item,
   output logic              push_ready,
   input  logic              pop,
   output logic              pop_valid,
   output grd_pkg::item_type pop_item
);

   grd_pkg::item_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_item   = slot_ff[rd_ptr_ff];
   assign do_push    = push & push_ready;
   assign do_pop     = pop & pop_valid;

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the incoming item
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== rtl/grd_back.sv =====
`timescale 1ns / 1ps

module grd_back (
   input  logic                                clock,
   input  logic                                reset,
   input  grd_pkg::cfg_type                    cfg,
   input  logic                                q_valid,
   input  grd_pkg::item_type                   q_item,
   output logic                                q_pop,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [grd_pkg::STATE_W-1:0]         rotation_state,
   output logic signed [grd_pkg::ANGLE_W-1:0]  angle,
   output logic                                tracking_active,
   output logic                                sample_ok
);

   // Detector state
   logic [grd_pkg::STATE_W-1:0]  state_ff, state_in;
   logic [grd_pkg::SETTLE_W-1:0] quiet_ff, quiet_in;
   logic [grd_pkg::TS_W-1:0]     last_ff, last_in;
   logic                         track_ff, track_in;

   // Stage A: detector result and multiplier operands
   logic                              sa_valid_ff;
   logic [grd_pkg::STATE_W-1:0]       sa_state_ff;
   logic                              sa_track_ff, sa_ok_ff, sa_clear_ff, sa_add_ff;
   logic signed [grd_pkg::DIFF_W-1:0] sa_diff_ff;
   logic [grd_pkg::TS_W-1:0]          sa_elapsed_ff;
   logic                              clear_in, add_in;
   logic [grd_pkg::TS_W-1:0]          elapsed_in;
   logic [grd_pkg::SETTLE_W-1:0]      quiet_inc;

   // Stage B: product
   logic                               sb_valid_ff;
   logic [grd_pkg::STATE_W-1:0]        sb_state_ff;
   logic                               sb_track_ff, sb_ok_ff, sb_clear_ff;
   logic signed [grd_pkg::PROD_W-1:0]  sb_prod_ff, prod_in;

   // Stage C: accumulator and result beat
   logic                               rsp_valid_ff;
   logic [grd_pkg::STATE_W-1:0]        out_state_ff;
   logic                               out_track_ff, out_ok_ff;
   logic signed [grd_pkg::ANGLE_W-1:0] angle_ff, angle_in;
   logic signed [grd_pkg::ANGLE_W:0]   sum;

   logic adv;

   // Whole pipeline moves unless the result beat is stalled
   assign adv   = !rsp_valid_ff || rsp_tready;
   assign q_pop = q_valid && adv;

   assign quiet_inc = (quiet_ff == grd_pkg::QUIET_MAX) ? quiet_ff
                                                        : quiet_ff + 8'd1;

   // Step the detector and prepare the integration
   always_comb begin
      state_in   = state_ff;
      quiet_in   = quiet_ff;
      track_in   = track_ff;
      last_in    = last_ff;
      clear_in   = 1'b0;
      add_in     = 1'b0;
      elapsed_in = '0;
      if (q_pop) begin
         if (q_item.cmd) begin
            state_in = grd_pkg::ST_IDLE;
            quiet_in = '0;
            track_in = 1'b1;
            last_in  = q_item.ts;
            clear_in = 1'b1;
         end else if (q_item.ok) begin
            unique case (state_ff)
               grd_pkg::ST_IDLE: begin
                  if (q_item.mag > cfg.threshold) begin
                     state_in = grd_pkg::ST_ROTATING;
                     quiet_in = '0;
                     track_in = 1'b1;
                     last_in  = q_item.ts;
                     clear_in = 1'b1;
                  end
               end
               grd_pkg::ST_ROTATING: begin
                  if (q_item.mag < cfg.threshold) begin
                     state_in = grd_pkg::ST_SETTLING;
                     quiet_in = 8'd1;
                  end
               end
               grd_pkg::ST_SETTLING: begin
                  if (q_item.mag < cfg.threshold) begin
                     quiet_in = quiet_inc;
                     if (quiet_inc >= cfg.settle) begin
                        state_in = grd_pkg::ST_DONE;
                        track_in = 1'b0;
                     end
                  end else begin
                     state_in = grd_pkg::ST_ROTATING;
                     quiet_in = '0;
                  end
               end
               grd_pkg::ST_DONE: begin
               end
               default: begin
               end
            endcase
            if (track_in) begin
               elapsed_in = q_item.ts - last_in;
               last_in    = q_item.ts;
               add_in     = (q_item.mag >= cfg.dead_band);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= grd_pkg::ST_IDLE;
         quiet_ff <= '0;
         track_ff <= 1'b0;
         last_ff  <= '0;
      end else begin
         state_ff <= state_in;
         quiet_ff <= quiet_in;
         track_ff <= track_in;
         last_ff  <= last_in;
      end
   end

   // Stage A registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sa_valid_ff <= 1'b0;
      end else if (adv) begin
         sa_valid_ff <= q_pop;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sa_state_ff   <= state_in;
         sa_track_ff   <= track_in;
         sa_ok_ff      <= !q_item.cmd && q_item.ok;
         sa_clear_ff   <= clear_in;
         sa_add_ff     <= add_in;
         sa_diff_ff    <= q_item.diff;
         sa_elapsed_ff <= elapsed_in;
      end
   end

   // Signed rate offset times elapsed milliseconds
   assign prod_in = $signed({{(grd_pkg::PROD_W-grd_pkg::DIFF_W){sa_diff_ff[grd_pkg::DIFF_W-1]}},
                             sa_diff_ff})
                  * $signed({{(grd_pkg::PROD_W-grd_pkg::TS_W){1'b0}}, sa_elapsed_ff});

   // Stage B registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sb_valid_ff <= 1'b0;
      end else if (adv) begin
         sb_valid_ff <= sa_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sb_state_ff <= sa_state_ff;
         sb_track_ff <= sa_track_ff;
         sb_ok_ff    <= sa_ok_ff;
         sb_clear_ff <= sa_clear_ff;
         sb_prod_ff  <= sa_add_ff ? prod_in : '0;
      end
   end

   // Saturating accumulate
   assign sum = {angle_ff[grd_pkg::ANGLE_W-1], angle_ff}
              + {{(grd_pkg::ANGLE_W+1-grd_pkg::PROD_W){sb_prod_ff[grd_pkg::PROD_W-1]}},
                 sb_prod_ff};

   always_comb begin
      if (sb_clear_ff) begin
         angle_in = '0;
      end else if (sum[grd_pkg::ANGLE_W] != sum[grd_pkg::ANGLE_W-1]) begin
         angle_in = sum[grd_pkg::ANGLE_W] ? grd_pkg::ANGLE_MIN : grd_pkg::ANGLE_MAX;
      end else begin
         angle_in = sum[grd_pkg::ANGLE_W-1:0];
      end
   end

   // Stage C registers: accumulator and result beat
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         angle_ff     <= '0;
      end else if (adv) begin
         rsp_valid_ff <= sb_valid_ff;
         if (sb_valid_ff) begin
            angle_ff <= angle_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv && sb_valid_ff) begin
         out_state_ff <= sb_state_ff;
         out_track_ff <= sb_track_ff;
         out_ok_ff    <= sb_ok_ff;
      end
   end

   assign rsp_tvalid      = rsp_valid_ff;
   assign rotation_state  = out_state_ff;
   assign angle           = angle_ff;
   assign tracking_active = out_track_ff;
   assign sample_ok       = out_ok_ff;

`ifndef SYNTHESIS
   a_done_stops_tracking: assert property (@(posedge clock) disable iff (reset)
      state_ff == grd_pkg::ST_DONE |-> !track_ff)
      else $error("tracking still on in done state");

   a_add_needs_tracking: assert property (@(posedge clock) disable iff (reset)
      sa_valid_ff && sa_add_ff |-> sa_track_ff && sa_ok_ff)
      else $error("integration without tracking or valid sample");

   // A clear restarts the time mark, so nothing can be added with it
   a_clear_sets_tracking: assert property (@(posedge clock) disable iff (reset)
      sa_valid_ff && sa_clear_ff |-> sa_track_ff && (sa_elapsed_ff == '0))
      else $error("angle clear with inconsistent flags");

   a_result_from_pipe: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(sb_valid_ff))
      else $error("result beat without an item in the pipe");
`endif

endmodule

// ===== rtl/gyro_rotation_detector_top.sv =====
`timescale 1ns / 1ps

// Rotation detector and angle integrator for a rate gyro.
// Input beats (req_): tuser carries cmd (0 converter sample, 1 restart),
// tdata carries the converter word and the millisecond timestamp.
// Every input beat yields exactly one result beat (rsp_) with the detector
// state, the 48-bit saturating angle, the tracking flag and sample_ok.
// Registers are written through csr_we/csr_addr/csr_wdata;
// write them only while no item is in flight.
// A result beat is registered in turn through the queue write on the
// accepting edge, then the detector, multiply and accumulate stages.
// Throughput: one item per cycle while no result beat is stalled, with
// the detector update feeding a 12x32 multiplier and a 48-bit saturating accumulator.
// A two-entry queue decouples input acceptance from the back pipeline.
// While a result beat waits on rsp_tready, the back pipeline holds; the
// queue keeps taking beats until its two entries are full, then req_tready drops.
// Reset (synchronous) empties the pipe, sets the detector to idle with
// tracking off and the angle zero, and loads the register defaults.

module gyro_rotation_detector_top (
   input  logic                                clock,
   input  logic                                reset,
   // req_tdata: raw_word [15:0], timestamp_ms [47:16]
   input  logic [47:0]                         req_tdata,
   // req_tuser: cmd
   input  logic                                req_tuser,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // rsp_tdata: rotation_state [1:0], angle [49:2], tracking_active [50], zero [55:51]
   output logic [55:0]                         rsp_tdata,
   // rsp_tuser: sample_ok
   output logic                                rsp_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic                                csr_we,
   input  logic [grd_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic [grd_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   grd_pkg::cfg_type  cfg_ff, cfg_in;
   grd_pkg::item_type push_item, pop_item;
   logic              q_ready, q_push, q_valid, q_pop;

   logic [grd_pkg::STATE_W-1:0]        rotation_state;
   logic signed [grd_pkg::ANGLE_W-1:0] angle;
   logic                               tracking_active;

   // Decode register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_addr)
            grd_pkg::CSR_ZERO_OFFSET: cfg_in.zero_offset = csr_wdata;
            grd_pkg::CSR_THRESHOLD:   cfg_in.threshold   = csr_wdata;
            grd_pkg::CSR_SETTLE:      cfg_in.settle      = csr_wdata[grd_pkg::SETTLE_W-1:0];
            grd_pkg::CSR_DEAD_BAND:   cfg_in.dead_band   = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.zero_offset <= grd_pkg::ZERO_OFFSET_RST;
         cfg_ff.threshold   <= grd_pkg::THRESHOLD_RST;
         cfg_ff.settle      <= grd_pkg::SETTLE_RST;
         cfg_ff.dead_band   <= grd_pkg::DEAD_BAND_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   grd_front u_front (
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .raw_word     (req_tdata[15:0]),
      .timestamp_ms (req_tdata[47:16]),
      .cmd          (req_tuser),
      .cfg          (cfg_ff),
      .q_ready      (q_ready),
      .q_push       (q_push),
      .q_item       (push_item)
   );

   grd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_item  (push_item),
      .push_ready (q_ready),
      .pop        (q_pop),
      .pop_valid  (q_valid),
      .pop_item   (pop_item)
   );

   grd_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .q_valid         (q_valid),
      .q_item          (pop_item),
      .q_pop           (q_pop),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rotation_state  (rotation_state),
      .angle           (angle),
      .tracking_active (tracking_active),
      .sample_ok       (rsp_tuser)
   );

   // Pack the result beat
   assign rsp_tdata = {5'd0, tracking_active, angle, rotation_state};

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

// One expected result beat
typedef struct packed {
   logic [grd_pkg::STATE_W-1:0]        state;
   logic signed [grd_pkg::ANGLE_W-1:0] angle;
   logic                               tracking;
   logic                               ok;
} rotation_result_type;

// Rotation detector predictor plus the queue of results still owed by the block
class rotation_scoreboard;
   int                           zero_offset;
   int                           threshold;
   int                           settle;
   int                           dead_band;
   logic [grd_pkg::STATE_W-1:0]  det_state;
   int                           quiet;
   longint                       angle;
   bit [31:0]                    last_ms;
   bit                           tracking;
   rotation_result_type          expected_q[$];
   int                           fail_count;

   function new();
      zero_offset = int'(grd_pkg::ZERO_OFFSET_RST);
      threshold   = int'(grd_pkg::THRESHOLD_RST);
      settle      = int'(grd_pkg::SETTLE_RST);
      dead_band   = int'(grd_pkg::DEAD_BAND_RST);
      det_state   = grd_pkg::ST_IDLE;
      quiet       = 0;
      angle       = 0;
      last_ms     = '0;
      tracking    = 1'b0;
      fail_count  = 0;
   endfunction

   function void set_reg(logic [grd_pkg::CSR_ADDR_W-1:0] idx, int val);
      case (idx)
         grd_pkg::CSR_ZERO_OFFSET: zero_offset = val & 'h7FF;
         grd_pkg::CSR_THRESHOLD:   threshold   = val & 'h7FF;
         grd_pkg::CSR_SETTLE:      settle      = val & 'hFF;
         grd_pkg::CSR_DEAD_BAND:   dead_band   = val & 'h7FF;
         default: ;
      endcase
   endfunction

   // Zero the angle and restart integration from this time mark
   function void restart_angle(bit [31:0] ts);
      angle    = 0;
      last_ms  = ts;
      tracking = 1'b1;
   endfunction

   // Advance the model by one accepted input beat
   function void note_item(bit cmd, bit [15:0] word, bit [31:0] ts);
      rotation_result_type r;
      int                  diff;
      int                  mag;
      bit [31:0]           elapsed;
      longint              sum;
      r.ok = 1'b0;
      if (cmd) begin
         det_state = grd_pkg::ST_IDLE;
         quiet     = 0;
         restart_angle(ts);
      end else if (word[grd_pkg::DONE_BIT_POS]) begin
         r.ok = 1'b1;
         diff = int'(word[grd_pkg::RATE_LSB +: grd_pkg::RATE_W]) - zero_offset;
         mag  = (diff < 0) ? -diff : diff;
         // detector step on the magnitude
         case (det_state)
            grd_pkg::ST_IDLE: begin
               if (mag > threshold) begin
                  det_state = grd_pkg::ST_ROTATING;
                  quiet     = 0;
                  restart_angle(ts);
               end
            end
            grd_pkg::ST_ROTATING: begin
               if (mag < threshold) begin
                  det_state = grd_pkg::ST_SETTLING;
                  quiet     = 1;
               end
            end
            grd_pkg::ST_SETTLING: begin
               if (mag < threshold) begin
                  if (quiet < 255) quiet++;
                  if (quiet >= settle) begin
                     det_state = grd_pkg::ST_DONE;
                     tracking  = 1'b0;
                  end
               end else begin
                  det_state = grd_pkg::ST_ROTATING;
                  quiet     = 0;
               end
            end
            default: ;
         endcase
         // integrate outside the dead band, time mark always advances
         if (tracking) begin
            elapsed = ts - last_ms;
            last_ms = ts;
            if (!(diff > -dead_band && diff < dead_band)) begin
               sum = angle + longint'(diff) * longint'({32'b0, elapsed});
               if (sum > longint'(grd_pkg::ANGLE_MAX)) sum = longint'(grd_pkg::ANGLE_MAX);
               if (sum < longint'(grd_pkg::ANGLE_MIN)) sum = longint'(grd_pkg::ANGLE_MIN);
               angle = sum;
            end
         end
      end
      r.state    = det_state;
      r.angle    = angle[grd_pkg::ANGLE_W-1:0];
      r.tracking = tracking;
      expected_q.push_back(r);
   endfunction

   // Compare one result beat with the oldest expectation
   function void check_result(logic [55:0] data, logic ok_bit);
      rotation_result_type         e;
      logic [grd_pkg::STATE_W-1:0] st;
      logic signed [47:0]          ang;
      logic                        trk;
      st  = data[1:0];
      ang = data[49:2];
      trk = data[50];
      if (expected_q.size() == 0) begin
         $error("result beat with nothing expected: state %0d angle %0d", st, ang);
         fail_count++;
         return;
      end
      e = expected_q.pop_front();
      if (st !== e.state) begin
         $error("rotation_state: expected %0d, actual %0d", e.state, st);
         fail_count++;
      end
      if (ang !== e.angle) begin
         $error("angle: expected %0d, actual %0d", e.angle, ang);
         fail_count++;
      end
      if (trk !== e.tracking) begin
         $error("tracking_active: expected %0d, actual %0d", e.tracking, trk);
         fail_count++;
      end
      if (ok_bit !== e.ok) begin
         $error("sample_ok: expected %0d, actual %0d", e.ok, ok_bit);
         fail_count++;
      end
   endfunction
endclass

module testbench;

   localparam int CYCLE_LIMIT = 300000;

   logic                           clock;
   logic                           reset;
   logic [47:0]                    req_tdata;
   logic                           req_tuser;
   logic                           req_tvalid;
   logic                           req_tready;
   logic [55:0]                    rsp_tdata;
   logic                           rsp_tuser;
   logic                           rsp_tvalid;
   logic                           rsp_tready;
   logic                           csr_we;
   logic [grd_pkg::CSR_ADDR_W-1:0] csr_addr;
   logic [grd_pkg::CSR_DATA_W-1:0] csr_wdata;

   rotation_scoreboard sb = new();

   bit [31:0] now_ms;
   int        items_sent;
   int        gap_max;
   int        stall_max;
   bit        hold_off_request;
   int        cycle_count;

   gyro_rotation_detector_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Watch both channels at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            sb.note_item(req_tuser, req_tdata[15:0], req_tdata[47:16]);
         if (rsp_tvalid && rsp_tready)
            sb.check_result(rsp_tdata, rsp_tuser);
      end
   end

   // Result side: random stalls per beat, one long hold-off on request
   initial begin
      int stall;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            stall = 80;
         end else begin
            stall = $urandom_range(stall_max, 0);
         end
         repeat (stall) begin
            @(negedge clock);
            rsp_tready <= 1'b0;
         end
         @(negedge clock);
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // Run limit
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("status: fail");
      $finish;
   end

   // Offer one beat after a random gap and hold it until taken
   task automatic send_item(input bit cmd, input logic [15:0] word, input logic [31:0] ts);
      int gap;
      gap = $urandom_range(gap_max, 0);
      repeat (gap) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {ts, word};
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   // Drop valid and wait for every owed result
   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (5) @(posedge clock);
   endtask

   task automatic write_reg(input logic [grd_pkg::CSR_ADDR_W-1:0] idx, input int val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val[grd_pkg::CSR_DATA_W-1:0];
      sb.set_reg(idx, val);
   endtask

   task automatic write_cfg(input int offset, input int thr, input int settle, input int db);
      wait_drained();
      write_reg(grd_pkg::CSR_ZERO_OFFSET, offset);
      write_reg(grd_pkg::CSR_THRESHOLD, thr);
      write_reg(grd_pkg::CSR_SETTLE, settle);
      write_reg(grd_pkg::CSR_DEAD_BAND, db);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic logic [15:0] sample_word(input int rate, input bit done);
      logic [15:0] w;
      w = 16'($urandom);
      w[grd_pkg::DONE_BIT_POS] = done;
      w[grd_pkg::RATE_LSB +: grd_pkg::RATE_W] = rate[grd_pkg::RATE_W-1:0];
      return w;
   endfunction

   // Mostly small time steps, sometimes none, now and then a huge jump
   function automatic logic [31:0] advance_ms();
      int r;
      r = $urandom_range(99, 0);
      if (r < 4) now_ms += $urandom;
      else if (r >= 10) now_ms += $urandom_range(50, 1);
      return now_ms;
   endfunction

   // Rate at a distance in [lo, hi] from the zero offset where it fits, else clamped to 0..2047
   function automatic int pick_rate(input int lo, input int hi);
      int mag;
      int rate;
      if (hi > 2047) hi = 2047;
      if (hi < 0) hi = 0;
      if (lo > hi) lo = hi;
      mag  = $urandom_range(hi, lo);
      rate = $urandom_range(1, 0) ? sb.zero_offset + mag : sb.zero_offset - mag;
      if (rate > 2047) rate = sb.zero_offset - mag;
      else if (rate < 0) rate = sb.zero_offset + mag;
      if (rate > 2047) rate = 2047;
      if (rate < 0) rate = 0;
      return rate;
   endfunction

   task automatic send_sample(input int rate);
      send_item(1'b0, sample_word(rate, 1'b1), advance_ms());
   endtask

   task automatic sample_at(input int rate, input logic [31:0] ts);
      send_item(1'b0, sample_word(rate, 1'b1), ts);
   endtask

   // Rotation episodes with random content, mixed with noise beats; stop at the count
   task automatic run_random(input int count);
      int          target;
      int          quiet_len;
      logic [15:0] w;
      target = items_sent + count;
      while (items_sent < target) begin
         if ($urandom_range(99, 0) < 15) begin
            w = 16'($urandom);
            case ($urandom_range(3, 0))
               0: send_item(1'b1, w, advance_ms());
               3: send_item(1'b0, w, advance_ms());
               default: begin
                  w[grd_pkg::DONE_BIT_POS] = 1'b0;
                  send_item(1'b0, w, advance_ms());
               end
            endcase
         end else begin
            if ($urandom_range(2, 0) == 0)
               send_item(1'b1, 16'($urandom), advance_ms());
            repeat ($urandom_range(6, 1)) begin
               if (items_sent < target)
                  send_sample(pick_rate(sb.threshold + 1, sb.threshold + 600));
            end
            quiet_len = $urandom_range(sb.settle + 2, 0);
            repeat (quiet_len) begin
               if (items_sent < target) begin
                  if ($urandom_range(19, 0) == 0)
                     send_sample(pick_rate(sb.threshold + 1, sb.threshold + 600));
                  else
                     send_sample(pick_rate(0, sb.threshold - 1));
               end
            end
            repeat ($urandom_range(3, 0)) begin
               if (items_sent < target)
                  send_sample(pick_rate(0, 2047));
            end
         end
      end
   endtask

   initial begin
      reset            = 1'b1;
      req_tvalid       = 1'b0;
      req_tuser        = 1'b0;
      req_tdata        = '0;
      csr_we           = 1'b0;
      csr_addr         = '0;
      csr_wdata        = '0;
      hold_off_request = 1'b0;
      items_sent       = 0;
      now_ms           = '0;
      gap_max          = 0;
      stall_max        = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed walk through the detector at reset settings, no idling
      send_item(1'b0, 16'hDFFF, 32'hFFFF_FFFF);
      send_item(1'b1, 16'hFFFF, 32'd100);
      sample_at(1008, 32'd105);
      sample_at(1017, 32'd110);
      sample_at(998, 32'd120);
      sample_at(1058, 32'd125);
      sample_at(1059, 32'd130);
      send_item(1'b0, 16'hFFFF, 32'd140);
      sample_at(0, 32'd150);
      sample_at(1058, 32'd160);
      sample_at(1057, 32'd170);
      sample_at(948, 32'd180);
      // quiet run across the timestamp wrap until done
      now_ms = 32'hFFFF_FFF8;
      for (int i = 0; i < 10; i++) begin
         sample_at(963 + i * 10, now_ms);
         now_ms += 3;
      end
      sample_at(2047, now_ms);
      send_item(1'b0, 16'h0000, now_ms + 1);
      send_item(1'b1, 16'h0000, 32'd0);

      // Drive the angle into positive then negative saturation
      gap_max   = 11;
      stall_max = 11;
      write_cfg(0, 0, 2, 0);
      now_ms = 32'd0;
      send_item(1'b1, 16'($urandom), now_ms);
      repeat (20) begin
         now_ms += 32'hFFFF_FFFF;
         send_item(1'b0, 16'hFFFF, now_ms);
      end
      write_cfg(2047, 0, 2, 0);
      repeat (36) begin
         now_ms += 32'hFFFF_FFFF;
         sample_at(0, now_ms);
      end

      // All registers at their top
      gap_max   = 11;
      stall_max = 0;
      write_cfg(2047, 2047, 255, 2047);
      run_random(64);

      // Long settling
      gap_max   = 0;
      stall_max = 11;
      write_cfg($urandom_range(1100, 900), 100, 40, 30);
      run_random(64);

      // Settling ends on the first further quiet sample; pause mid-phase
      gap_max   = 11;
      stall_max = 11;
      write_cfg($urandom_range(2047, 0), $urandom_range(300, 1), 1, $urandom_range(100, 0));
      run_random(32);
      wait_drained();
      run_random(32);

      // Random settings; receiver holds off while beats keep coming
      gap_max   = 0;
      stall_max = 0;
      write_cfg($urandom_range(2047, 0), $urandom_range(400, 1), $urandom_range(20, 2),
                $urandom_range(200, 0));
      run_random(32);
      hold_off_request = 1'b1;
      run_random(32);

      // Back to reset values
      gap_max   = 5;
      stall_max = 11;
      write_cfg(1008, 50, 10, 10);
      run_random(64);

      wait_drained();
      repeat (10) @(posedge clock);
      if (sb.fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/grd_pkg.sv
rtl/grd_front.sv
rtl/grd_queue.sv
rtl/grd_back.sv
rtl/gyro_rotation_detector_top.sv
sim/testbench.sv
